/* sv/kpvf_pkg.sv */
// kpvf_pkg: shared types, constants, saturation helpers and the step program
// of the position/velocity tracking filter. No dependencies.
package kpvf_pkg;

  localparam int DW = 52;
  localparam int PCW = 6;
  localparam int PROG_LEN = 37;
  localparam int NREG = 25;

  typedef logic signed [DW-1:0] word_t;

  localparam word_t MAX48 = {5'b0, {47{1'b1}}};
  localparam word_t MIN48 = {5'h1f, 47'b0};
  localparam word_t MAX32 = {21'b0, {31{1'b1}}};
  localparam word_t MIN32 = {{21{1'b1}}, 31'b0};
  localparam word_t COV_INIT = word_t'(52'd10 << 24);

  localparam logic [31:0] MEAS_VAR_RST = 32'h0001_0000;
  localparam logic [31:0] INIT_POS_RST = 32'h0000_0000;
  localparam logic [31:0] INIT_VEL_RST = 32'h0000_0000;
  localparam logic [31:0] INIT_VVAR_RST = 32'h0001_0000;

  typedef enum logic [1:0] {
    CFG_MEAS_VAR, CFG_INIT_POS, CFG_INIT_VEL, CFG_INIT_VVAR
  } cfg_e;

  typedef enum logic [2:0] {
    OP_MUL, OP_MULC, OP_DIV, OP_ADD, OP_SUB, OP_ADDC, OP_SUBC, OP_ADD32
  } op_e;

  typedef enum logic [4:0] {
    R_T, R_T2, R_T3, R_T4, R_Q, R_ZM, R_MV, R_POS, R_VEL,
    R_PPP, R_PPV, R_PVP, R_PVV, R_A, R_B, R_C, R_D,
    R_PZZ, R_PZV, R_PVZ, R_PVVN, R_Y, R_DEN, R_KZ, R_KV
  } reg_e;

  typedef enum logic [2:0] {
    ST_LOAD, ST_IDLE, ST_FETCH, ST_EXEC, ST_WAIT, ST_OUT
  } state_e;

  typedef struct packed {
    op_e        op;
    reg_e       dst;
    reg_e       src_a;
    reg_e       src_b;
    logic [5:0] sh;
  } uop_t;

  typedef struct packed {
    logic       start;
    logic       sat;
    logic [5:0] sh;
  } mul_ctl_t;

  function automatic word_t sat48(word_t x);
    word_t r;
    r = x;
    if (x > MAX48) r = MAX48;
    else if (x < MIN48) r = MIN48;
    return r;
  endfunction

  function automatic word_t sat32(word_t x);
    word_t r;
    r = x;
    if (x > MAX32) r = MAX32;
    else if (x < MIN32) r = MIN32;
    return r;
  endfunction

  function automatic uop_t uop_at(logic [PCW-1:0] pc);
    uop_t u;
    case (pc)
      6'd0:  u = '{OP_MUL,   R_T2,   R_T,    R_T,    6'd0};
      6'd1:  u = '{OP_MUL,   R_T3,   R_T2,   R_T,    6'd16};
      6'd2:  u = '{OP_MUL,   R_T4,   R_T3,   R_T,    6'd16};
      6'd3:  u = '{OP_MUL,   R_A,    R_VEL,  R_T,    6'd16};
      6'd4:  u = '{OP_ADD32, R_POS,  R_POS,  R_A,    6'd0};
      6'd5:  u = '{OP_MULC,  R_A,    R_PPV,  R_T,    6'd16};
      6'd6:  u = '{OP_ADD,   R_B,    R_PPP,  R_A,    6'd0};
      6'd7:  u = '{OP_MULC,  R_A,    R_PVP,  R_T,    6'd16};
      6'd8:  u = '{OP_ADD,   R_B,    R_B,    R_A,    6'd0};
      6'd9:  u = '{OP_MULC,  R_A,    R_PVV,  R_T2,   6'd32};
      6'd10: u = '{OP_ADD,   R_B,    R_B,    R_A,    6'd0};
      6'd11: u = '{OP_MULC,  R_A,    R_Q,    R_T4,   6'd26};
      6'd12: u = '{OP_ADDC,  R_PZZ,  R_B,    R_A,    6'd0};
      6'd13: u = '{OP_MULC,  R_C,    R_PVV,  R_T,    6'd16};
      6'd14: u = '{OP_ADD,   R_B,    R_PPV,  R_C,    6'd0};
      6'd15: u = '{OP_MULC,  R_D,    R_Q,    R_T3,   6'd25};
      6'd16: u = '{OP_ADDC,  R_PZV,  R_B,    R_D,    6'd0};
      6'd17: u = '{OP_ADD,   R_B,    R_PVP,  R_C,    6'd0};
      6'd18: u = '{OP_ADDC,  R_PVZ,  R_B,    R_D,    6'd0};
      6'd19: u = '{OP_MULC,  R_A,    R_Q,    R_T2,   6'd24};
      6'd20: u = '{OP_ADDC,  R_PVVN, R_PVV,  R_A,    6'd0};
      6'd21: u = '{OP_SUB,   R_Y,    R_ZM,   R_POS,  6'd0};
      6'd22: u = '{OP_ADD,   R_DEN,  R_PZZ,  R_MV,   6'd0};
      6'd23: u = '{OP_DIV,   R_KZ,   R_PZZ,  R_DEN,  6'd0};
      6'd24: u = '{OP_DIV,   R_KV,   R_PZV,  R_DEN,  6'd0};
      6'd25: u = '{OP_MUL,   R_A,    R_KZ,   R_Y,    6'd24};
      6'd26: u = '{OP_ADD32, R_POS,  R_POS,  R_A,    6'd0};
      6'd27: u = '{OP_MUL,   R_A,    R_KV,   R_Y,    6'd24};
      6'd28: u = '{OP_ADD32, R_VEL,  R_VEL,  R_A,    6'd0};
      6'd29: u = '{OP_MULC,  R_A,    R_PZV,  R_KV,   6'd24};
      6'd30: u = '{OP_SUBC,  R_PVV,  R_PVVN, R_A,    6'd0};
      6'd31: u = '{OP_MULC,  R_A,    R_PZV,  R_KZ,   6'd24};
      6'd32: u = '{OP_SUBC,  R_PPV,  R_PZV,  R_A,    6'd0};
      6'd33: u = '{OP_MULC,  R_A,    R_PZZ,  R_KV,   6'd24};
      6'd34: u = '{OP_SUBC,  R_PVP,  R_PVZ,  R_A,    6'd0};
      6'd35: u = '{OP_MULC,  R_A,    R_PZZ,  R_KZ,   6'd24};
      6'd36: u = '{OP_SUBC,  R_PPP,  R_PZZ,  R_A,    6'd0};
      default: u = '{OP_ADD, R_A, R_A, R_A, 6'd0};
    endcase
    return u;
  endfunction

endpackage

/* sv/kpvf_mul.sv */
// kpvf_mul: signed multiply with rounding right shift and saturation,
// summed from four 24x24 partial products. Depends on kpvf_pkg.
module kpvf_mul import kpvf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mul_ctl_t ctl_i,
  input  word_t    a_i,
  input  word_t    b_i,
  output logic     done_o,
  output word_t    res_o
);

  localparam int MW = 48;
  localparam int HW = 24;
  localparam int PW = 2 * MW;
  localparam int SW = 49;

  logic          busy_q;
  logic [2:0]    step_q;
  logic          done_q;
  logic [MW-1:0] ma_q, mb_q;
  logic          neg_q, sat_q;
  logic [5:0]    sh_q;
  logic [PW-1:0] acc_q;
  word_t         res_q;

  logic [DW-1:0]   abs_a, abs_b;
  logic [HW-1:0]   ca, cb;
  logic [2*HW-1:0] pp;
  logic [1:0]      ij;
  logic [PW-1:0]   pp_sh, rnd, rs;
  logic [SW-1:0]   mag;
  word_t           sv;

  assign abs_a = a_i[DW-1] ? DW'(-a_i) : DW'(a_i);
  assign abs_b = b_i[DW-1] ? DW'(-b_i) : DW'(b_i);

  always_comb begin
    ca = step_q[0] ? ma_q[MW-1:HW] : ma_q[HW-1:0];
    cb = step_q[1] ? mb_q[MW-1:HW] : mb_q[HW-1:0];
    pp = ca * cb;
    ij = {1'b0, step_q[0]} + {1'b0, step_q[1]};
    case (ij)
      2'd0: pp_sh = PW'(pp);
      2'd1: pp_sh = PW'(pp) << HW;
      2'd2: pp_sh = PW'(pp) << (2 * HW);
      default: pp_sh = '0;
    endcase
    rnd = (sh_q == 6'd0) ? '0 : (PW'(1) << (sh_q - 6'd1));
    rs = (acc_q + rnd) >> sh_q;
    mag = (acc_q[PW-1:SW] != '0) ? {SW{1'b1}} : acc_q[SW-1:0];
    sv = neg_q ? -word_t'({{(DW-SW){1'b0}}, mag}) : word_t'({{(DW-SW){1'b0}}, mag});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        if (step_q == 3'd5) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          step_q <= step_q + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      ma_q  <= abs_a[MW-1:0];
      mb_q  <= abs_b[MW-1:0];
      neg_q <= a_i[DW-1] ^ b_i[DW-1];
      sat_q <= ctl_i.sat;
      sh_q  <= ctl_i.sh;
      acc_q <= '0;
    end else if (busy_q) begin
      if (step_q < 3'd4) acc_q <= acc_q + pp_sh;
      else if (step_q == 3'd4) acc_q <= rs;
      else res_q <= sat_q ? sat48(sv) : sv;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

/* sv/kpvf_div.sv */
// kpvf_div: signed Q.24 gain quotient, one restoring step per cycle,
// saturating to 47 bits of magnitude. Depends on kpvf_pkg.
module kpvf_div import kpvf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  word_t num_i,
  input  word_t den_i,
  output logic  done_o,
  output word_t res_o
);

  localparam int RW = 48;
  localparam int QW = 47;
  localparam int IB = 23;

  logic          busy_q, done_q, neg_q;
  logic [5:0]    cnt_q;
  logic [RW-1:0] rem_q, ud_q;
  logic [QW-1:0] dv_q, quo_q;
  word_t         res_q;

  logic [DW-1:0]    abs_n, abs_d;
  logic [RW-1:0]    un, ud;
  logic             den_zero, too_big, neg;
  logic [RW:0]      rem2, diff;
  logic             ge;

  always_comb begin
    abs_n    = num_i[DW-1] ? DW'(-num_i) : DW'(num_i);
    abs_d    = den_i[DW-1] ? DW'(-den_i) : DW'(den_i);
    un       = abs_n[RW-1:0];
    ud       = abs_d[RW-1:0];
    den_zero = (ud == '0);
    too_big  = {{IB{1'b0}}, un} >= {ud, {IB{1'b0}}};
    neg      = num_i[DW-1] ^ den_i[DW-1];
    rem2     = {rem_q, dv_q[QW-1]};
    diff     = rem2 - {1'b0, ud_q};
    ge       = rem2 >= {1'b0, ud_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        if (den_zero || too_big) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          cnt_q  <= 6'(QW);
        end
      end else if (busy_q) begin
        if (cnt_q != '0) begin
          cnt_q <= cnt_q - 6'd1;
        end else begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= neg;
      rem_q <= un >> IB;
      dv_q  <= {un[IB-1:0], {(QW-IB){1'b0}}};
      ud_q  <= ud;
      quo_q <= '0;
      if (den_zero) begin
        if (num_i[DW-1]) res_q <= -MAX48;
        else if (num_i != '0) res_q <= MAX48;
        else res_q <= '0;
      end else if (too_big) begin
        res_q <= neg ? -MAX48 : MAX48;
      end
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        rem_q <= ge ? diff[RW-1:0] : rem2[RW-1:0];
        quo_q <= {quo_q[QW-2:0], ge};
        dv_q  <= dv_q << 1;
      end else begin
        res_q <= neg_q ? -word_t'({{(DW-QW){1'b0}}, quo_q})
                       : word_t'({{(DW-QW){1'b0}}, quo_q});
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

/* sv/kalman_position_velocity_filter.sv */
// kalman_position_velocity_filter: top level, step sequencer, operand store
// and configuration. Depends on kpvf_pkg, kpvf_mul and kpvf_div.
//
//   channel  | handshake                 | payload
//   in       | in_valid_i / in_ready_o   | measured_position_i, accel_variance_i, time_step_i
//   out      | out_valid_o / out_ready_i | position_estimate_o, velocity_estimate_o
//   cfg      | cfg_we_i                  | cfg_index_i, cfg_wdata_i
//
// A transaction runs a 37 step program on one multiplier (17 products), one divider (twice,
// cut short when the gain saturates early) and 18 adds, plus the accept and output states.
// not ready while a transaction is in flight; the result register lets the next
// transaction be taken while the previous result still waits on out_ready_i.
// after reset and after every configuration write a covariance reload runs
// with in_ready_o low.
module kalman_position_velocity_filter import kpvf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] measured_position_i,
  input  logic [31:0]        accel_variance_i,
  input  logic [19:0]        time_step_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] position_estimate_o,
  output logic signed [31:0] velocity_estimate_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_wdata_i
);

  localparam logic [PCW-1:0] PC_LAST = PCW'(PROG_LEN - 1);

  state_e state_q, state_d;
  logic [PCW-1:0] pc_q;
  logic [1:0] ld_cnt_q;

  logic [31:0] mv_q, ipos_q, ivel_q, ivv_q;
  logic [19:0] t_q;
  logic [31:0] q_q;
  logic signed [31:0] zm_q, pos_q, vel_q;

  word_t mem_q [NREG];
  word_t rd_a_q, rd_b_q;

  logic signed [31:0] pos_out_q, vel_out_q;
  logic out_valid_q;

  uop_t  uop;
  word_t opa, opb, alu_res, wr_val;
  logic  is_unit, unit_done, wr_fire, last, accept, out_load;
  logic  mul_done, div_done, div_start;
  word_t mul_res, div_res;
  mul_ctl_t mul_ctl;
  reg_e  ld_dst;
  word_t ld_val;

  assign uop     = uop_at(pc_q);
  assign is_unit = (uop.op == OP_MUL) || (uop.op == OP_MULC) || (uop.op == OP_DIV);
  assign last    = (pc_q == PC_LAST);
  assign unit_done = (uop.op == OP_DIV) ? div_done : mul_done;

  always_comb begin
    case (uop.src_a)
      R_T:     opa = word_t'({32'b0, t_q});
      R_Q:     opa = word_t'({20'b0, q_q});
      R_ZM:    opa = word_t'(zm_q);
      R_MV:    opa = word_t'({12'b0, mv_q, 8'b0});
      R_POS:   opa = word_t'(pos_q);
      R_VEL:   opa = word_t'(vel_q);
      default: opa = rd_a_q;
    endcase
  end

  always_comb begin
    case (uop.src_b)
      R_T:     opb = word_t'({32'b0, t_q});
      R_Q:     opb = word_t'({20'b0, q_q});
      R_ZM:    opb = word_t'(zm_q);
      R_MV:    opb = word_t'({12'b0, mv_q, 8'b0});
      R_POS:   opb = word_t'(pos_q);
      R_VEL:   opb = word_t'(vel_q);
      default: opb = rd_b_q;
    endcase
  end

  always_comb begin
    case (uop.op)
      OP_ADD:   alu_res = opa + opb;
      OP_SUB:   alu_res = opa - opb;
      OP_ADDC:  alu_res = sat48(opa + opb);
      OP_SUBC:  alu_res = sat48(opa - opb);
      OP_ADD32: alu_res = sat32(opa + opb);
      default:  alu_res = opa + opb;
    endcase
  end

  assign wr_val = (state_q == ST_WAIT) ? ((uop.op == OP_DIV) ? div_res : mul_res) : alu_res;

  always_comb begin
    case (ld_cnt_q)
      2'd0:    begin ld_dst = R_PPP; ld_val = COV_INIT; end
      2'd1:    begin ld_dst = R_PPV; ld_val = '0; end
      2'd2:    begin ld_dst = R_PVP; ld_val = '0; end
      default: begin ld_dst = R_PVV; ld_val = word_t'({12'b0, ivv_q, 8'b0}); end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD:  if (ld_cnt_q == 2'd3) state_d = ST_IDLE;
      ST_IDLE:  if (in_valid_i && !cfg_we_i) state_d = ST_FETCH;
      ST_FETCH: state_d = ST_EXEC;
      ST_EXEC:  if (is_unit) state_d = ST_WAIT;
                else state_d = last ? ST_OUT : ST_FETCH;
      ST_WAIT:  if (unit_done) state_d = last ? ST_OUT : ST_FETCH;
      ST_OUT:   if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:  state_d = ST_LOAD;
    endcase
    if (cfg_we_i) state_d = ST_LOAD;
  end

  // outputs of the sequencer
  always_comb begin
    in_ready_o    = (state_q == ST_IDLE) && !cfg_we_i;
    accept        = in_valid_i && in_ready_o;
    mul_ctl.start = (state_q == ST_EXEC) && ((uop.op == OP_MUL) || (uop.op == OP_MULC));
    mul_ctl.sat   = (uop.op == OP_MULC);
    mul_ctl.sh    = uop.sh;
    div_start     = (state_q == ST_EXEC) && (uop.op == OP_DIV);
    wr_fire       = ((state_q == ST_EXEC) && !is_unit) || ((state_q == ST_WAIT) && unit_done);
    out_load      = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      pc_q        <= '0;
      ld_cnt_q    <= '0;
      out_valid_q <= 1'b0;
      mv_q        <= MEAS_VAR_RST;
      ipos_q      <= INIT_POS_RST;
      ivel_q      <= INIT_VEL_RST;
      ivv_q       <= INIT_VVAR_RST;
      pos_q       <= '0;
      vel_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_load || (out_valid_q && !out_ready_i);
      if (accept) pc_q <= '0;
      else if (wr_fire && !last) pc_q <= pc_q + PCW'(1);
      if (cfg_we_i) ld_cnt_q <= '0;
      else if (state_q == ST_LOAD) ld_cnt_q <= ld_cnt_q + 2'd1;
      if (cfg_we_i) begin
        case (cfg_e'(cfg_index_i))
          CFG_MEAS_VAR:  mv_q   <= cfg_wdata_i;
          CFG_INIT_POS:  ipos_q <= cfg_wdata_i;
          CFG_INIT_VEL:  ivel_q <= cfg_wdata_i;
          CFG_INIT_VVAR: ivv_q  <= cfg_wdata_i;
          default:       mv_q   <= mv_q;
        endcase
      end
      if (state_q == ST_LOAD && ld_cnt_q == 2'd0 && !cfg_we_i) begin
        pos_q <= ipos_q;
        vel_q <= ivel_q;
      end else if (wr_fire && uop.dst == R_POS) begin
        pos_q <= wr_val[31:0];
      end else if (wr_fire && uop.dst == R_VEL) begin
        vel_q <= wr_val[31:0];
      end
    end
  end

  // operand store
  always_ff @(posedge clk_i) begin
    rd_a_q <= mem_q[uop.src_a];
    rd_b_q <= mem_q[uop.src_b];
    if (state_q == ST_LOAD) begin
      mem_q[ld_dst] <= ld_val;
    end else if (wr_fire && uop.dst != R_POS && uop.dst != R_VEL) begin
      mem_q[uop.dst] <= wr_val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      t_q  <= time_step_i;
      q_q  <= accel_variance_i;
      zm_q <= measured_position_i;
    end
    if (out_load) begin
      pos_out_q <= pos_q;
      vel_out_q <= vel_q;
    end
  end

  kpvf_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mul_ctl),
    .a_i    (opa),
    .b_i    (opb),
    .done_o (mul_done),
    .res_o  (mul_res)
  );

  kpvf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (opa),
    .den_i   (opb),
    .done_o  (div_done),
    .res_o   (div_res)
  );

  assign out_valid_o         = out_valid_q;
  assign position_estimate_o = pos_out_q;
  assign velocity_estimate_o = vel_out_q;

`ifndef SYNTH
  a_units_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mul_ctl.start && div_start)) else $error("both units started");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o) else $error("ready after accept");
  a_mul_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == ST_WAIT)) else $error("stray multiplier result");
  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q <= PC_LAST) else $error("step counter out of range");
`endif

endmodule

/* test/kalman_position_velocity_filter_tb.sv */
// kalman_position_velocity_filter_tb: self-checking bench for the position/velocity
// tracking filter, with a bit-exact fixed point predictor and random flow control.
// Depends on kpvf_pkg and the kalman_position_velocity_filter RTL.
module kalman_position_velocity_filter_tb import kpvf_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [127:0] big_t;

  typedef struct packed {
    logic signed [31:0] pos;
    logic signed [31:0] vel;
  } estimate_t;

  localparam big_t SAT48_HI = (big_t'(1) <<< 47) - 1;
  localparam big_t SAT48_LO = -(big_t'(1) <<< 47);
  localparam big_t SAT32_HI = (big_t'(1) <<< 31) - 1;
  localparam big_t SAT32_LO = -(big_t'(1) <<< 31);
  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_CYCLES = 1500;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o;
  logic signed [31:0] measured_position_i;
  logic [31:0] accel_variance_i;
  logic [19:0] time_step_i;
  logic out_valid_o, out_ready_i;
  logic signed [31:0] position_estimate_o, velocity_estimate_o;
  logic cfg_we_i;
  logic [1:0] cfg_index_i;
  logic [31:0] cfg_wdata_i;

  kalman_position_velocity_filter DUT (.*);

  // filter configuration and state as tracked by the bench
  logic [31:0] meas_var, init_pos, init_vel, init_vvar;
  big_t trk_pos, trk_vel, cov_pp, cov_pv, cov_vp, cov_vv;

  estimate_t pending_estimates[$];
  int errors = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  bit steady_send = 0;
  int stall_mode = 0;
  bit hold_req = 0;
  int cyc = 0;

  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic big_t clamp(big_t x, big_t lo, big_t hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  function automatic big_t c48(big_t x);
    return clamp(x, SAT48_LO, SAT48_HI);
  endfunction

  // rounded (a*b) >> sh, ties away from zero, magnitude capped at 2^63-1
  function automatic big_t mul_round(big_t a, big_t b, int sh);
    logic [127:0] ua, ub, r;
    ua = a < 0 ? -a : a;
    ub = b < 0 ? -b : b;
    r = ((ua * ub) + (128'd1 << (sh - 1))) >> sh;
    if (r >= (128'd1 << 63)) r = (128'd1 << 63) - 1;
    return ((a < 0) != (b < 0)) ? -big_t'(r) : big_t'(r);
  endfunction

  function automatic big_t kalman_gain(big_t num, big_t den);
    logic [127:0] un, ud, q;
    if (den == 0) return num > 0 ? SAT48_HI : (num < 0 ? -SAT48_HI : big_t'(0));
    un = num < 0 ? -num : num;
    ud = den < 0 ? -den : den;
    if (un / ud >= (128'd1 << 23)) q = SAT48_HI;
    else q = (un << 24) / ud;
    return ((num < 0) != (den < 0)) ? -big_t'(q) : big_t'(q);
  endfunction

  function automatic void load_initial();
    trk_pos = big_t'(signed'(init_pos));
    trk_vel = big_t'(signed'(init_vel));
    cov_pp = big_t'(10) <<< 24;
    cov_pv = 0;
    cov_vp = 0;
    cov_vv = big_t'({init_vvar, 8'd0});
  endfunction

  function automatic estimate_t filter_step(logic signed [31:0] zm, logic [31:0] q_in,
                                            logic [19:0] t_in);
    big_t t, t2, t3, t4, q, pzz, pzv, pvz, pvv, y, den, kz, kv;
    estimate_t e;
    t = big_t'(t_in);
    q = big_t'(q_in);
    t2 = t * t;
    t3 = mul_round(t2, t, 16);
    t4 = mul_round(t3, t, 16);
    trk_pos = clamp(trk_pos + mul_round(trk_vel, t, 16), SAT32_LO, SAT32_HI);
    pzz = c48(cov_pp + c48(mul_round(cov_pv, t, 16)) + c48(mul_round(cov_vp, t, 16))
              + c48(mul_round(cov_vv, t2, 32)) + c48(mul_round(q, t4, 26)));
    pzv = c48(cov_pv + c48(mul_round(cov_vv, t, 16)) + c48(mul_round(q, t3, 25)));
    pvz = c48(cov_vp + c48(mul_round(cov_vv, t, 16)) + c48(mul_round(q, t3, 25)));
    pvv = c48(cov_vv + c48(mul_round(q, t2, 24)));
    y = big_t'(zm) - trk_pos;
    den = pzz + big_t'({meas_var, 8'd0});
    kz = kalman_gain(pzz, den);
    kv = kalman_gain(pzv, den);
    trk_pos = clamp(trk_pos + mul_round(kz, y, 24), SAT32_LO, SAT32_HI);
    trk_vel = clamp(trk_vel + mul_round(kv, y, 24), SAT32_LO, SAT32_HI);
    cov_vv = c48(pvv - c48(mul_round(pzv, kv, 24)));
    cov_pv = c48(pzv - c48(mul_round(pzv, kz, 24)));
    cov_vp = c48(pvz - c48(mul_round(pzz, kv, 24)));
    cov_pp = c48(pzz - c48(mul_round(pzz, kz, 24)));
    e.pos = trk_pos[31:0];
    e.vel = trk_vel[31:0];
    return e;
  endfunction

  // sender: called at a falling edge, returns at a falling edge
  task automatic send_sample(logic signed [31:0] zm, logic [31:0] q, logic [19:0] t);
    int gap;
    gap = 0;
    if (!steady_send) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 20);
        burst_left = $urandom_range(1, 10);
      end else begin
        burst_left--;
      end
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    measured_position_i <= zm;
    accel_variance_i <= q;
    time_step_i <= t;
    do @(posedge clk_i); while (!in_ready_o);
    pending_estimates.push_back(filter_step(zm, q, t));
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_estimates.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_cfg(cfg_e idx, logic [31:0] value);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_MEAS_VAR: meas_var = value;
      CFG_INIT_POS: init_pos = value;
      CFG_INIT_VEL: init_vel = value;
      CFG_INIT_VVAR: init_vvar = value;
    endcase
    load_initial();
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return 32'(signed'(trk_pos[31:0])) + 32'($urandom_range(0, 8'hff) << 12)
                      - 32'h0008_0000;
    endcase
  endfunction

  function automatic logic [31:0] rand_qvar();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0;
      default: return $urandom_range(0, 32'h0004_0000);
    endcase
  endfunction

  function automatic logic [19:0] rand_dt();
    case ($urandom_range(0, 3))
      0: return 20'($urandom_range(1, 20'hfffff));
      1: return $urandom_range(0, 1) ? 20'hfffff : 20'h00001;
      default: return 20'($urandom_range(20'h00100, 20'h02000));
    endcase
  endfunction

  task automatic test_reset_defaults();
    send_sample(32'sh0, 32'h0, 20'h10000);
    send_sample(32'sh0001_0000, 32'h0001_0000, 20'h01999);
    send_sample(32'sh0002_0000, 32'h0001_0000, 20'h01999);
    drain();
  endtask

  task automatic test_field_extremes();
    send_sample(32'sh7fff_ffff, 32'hffff_ffff, 20'hfffff);
    send_sample(-32'sh8000_0000, 32'hffff_ffff, 20'hfffff);
    send_sample(32'sh7fff_ffff, 32'h0, 20'h00001);
    send_sample(-32'sh8000_0000, 32'h0, 20'h00001);
    send_sample(32'sh0, 32'h8000_0000, 20'h80000);
    send_sample(32'sh5555_5555, 32'haaaa_aaaa, 20'h55555);
    send_sample(-32'sh5555_5556, 32'h5555_5555, 20'haaaaa);
    drain();
    write_cfg(CFG_INIT_POS, 32'h0);
    send_sample(32'sh0, 32'h0, 20'h00001);
    send_sample(32'sh0, 32'h0, 20'h00001);
    drain();
  endtask

  task automatic test_config_extremes();
    write_cfg(CFG_MEAS_VAR, 32'h0);
    send_sample(32'sh0003_0000, 32'h0, 20'h00001);
    send_sample(-32'sh0003_0000, 32'h0, 20'h10000);
    drain();
    write_cfg(CFG_MEAS_VAR, 32'hffff_ffff);
    write_cfg(CFG_INIT_POS, 32'h7fff_ffff);
    write_cfg(CFG_INIT_VEL, 32'h7fff_ffff);
    write_cfg(CFG_INIT_VVAR, 32'hffff_ffff);
    send_sample(32'sh7fff_0000, 32'hffff_ffff, 20'hfffff);
    send_sample(-32'sh8000_0000, 32'h0001_0000, 20'h10000);
    drain();
    write_cfg(CFG_INIT_POS, 32'h8000_0000);
    write_cfg(CFG_INIT_VEL, 32'h8000_0000);
    write_cfg(CFG_INIT_VVAR, 32'h0);
    send_sample(-32'sh8000_0000, 32'h0, 20'h10000);
    send_sample(32'sh7fff_ffff, 32'h0, 20'h10000);
    drain();
    write_cfg(CFG_MEAS_VAR, 32'h0001_0000);
    write_cfg(CFG_INIT_POS, 32'h0);
    write_cfg(CFG_INIT_VEL, 32'h0);
    write_cfg(CFG_INIT_VVAR, 32'h0001_0000);
  endtask

  task automatic test_output_backpressure();
    hold_req = 1;
    steady_send = 1;
    repeat (6) send_sample(rand_pos(), rand_qvar(), rand_dt());
    steady_send = 0;
    drain();
  endtask

  task automatic test_random_tracking();
    for (int phase = 0; phase < 8; phase++) begin
      write_cfg(CFG_MEAS_VAR, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h8_0000));
      write_cfg(CFG_INIT_POS, $urandom);
      write_cfg(CFG_INIT_VEL, $urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 32'h3_ffff)));
      write_cfg(CFG_INIT_VVAR, $urandom);
      stall_mode = phase % 3;
      steady_send = (phase % 4) == 3;
      repeat (210) send_sample(rand_pos(), rand_qvar(), rand_dt());
      drain();
    end
    stall_mode = 0;
  endtask

  // receiver flow control
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      cyc++;
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 0;
      end
      case (stall_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= ($urandom_range(0, 9) > 3);
        default: out_ready_i <= (cyc % 11) > 4;
      endcase
    end
  end

  always @(posedge clk_i) begin
    estimate_t exp_e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_estimates.size() == 0) begin
        $error("position_estimate: unexpected transaction, actual %0d", position_estimate_o);
        errors++;
      end else begin
        exp_e = pending_estimates.pop_front();
        if (position_estimate_o !== exp_e.pos) begin
          $error("position_estimate: expected %0d actual %0d", exp_e.pos, position_estimate_o);
          errors++;
        end
        if (velocity_estimate_o !== exp_e.vel) begin
          $error("velocity_estimate: expected %0d actual %0d", exp_e.vel, velocity_estimate_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    measured_position_i = '0;
    accel_variance_i = '0;
    time_step_i = '0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_MEAS_VAR;
    cfg_wdata_i = '0;
    meas_var = MEAS_VAR_RST;
    init_pos = INIT_POS_RST;
    init_vel = INIT_VEL_RST;
    init_vvar = INIT_VVAR_RST;
    load_initial();
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_reset_defaults();
    test_field_extremes();
    test_config_extremes();
    test_output_backpressure();
    test_random_tracking();
    if (pending_estimates.size() != 0) begin
      $error("position_estimate: %0d expected transactions never arrived",
             pending_estimates.size());
      errors++;
    end
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
